/* rtl/bcg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_pkg: shared types and constants for the battery charge gauge
// Field widths, breakpoint tables, divider sizing and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bcg_pkg;

    localparam int ADC_W    = 12;
    localparam int MV_W     = 13;
    localparam int PCT_W    = 7;
    localparam int SUM_W    = 16;
    localparam int CNT_W    = 4;
    localparam int BP_IDX_W = 4;

    localparam int SAMPLES_PER_READING_DEF = 10;
    localparam logic [ADC_W-1:0] FULL_COUNT_RST = 12'd2280;

    localparam logic [MV_W-1:0] MV_FULL  = 13'd4200;
    localparam logic [MV_W-1:0] MV_EMPTY = 13'd3300;
    localparam logic [MV_W-1:0] MV_MAX   = 13'd8191;
    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;
    localparam int BP_COUNT = 11;

    // divider: 25-bit dividend, 12-bit divisor, one quotient bit per cycle
    localparam int NUM_W    = 25;
    localparam int DEN_W    = 12;
    localparam int STEP_W   = 5;
    localparam int PCT_NUM_W = 12;

    // reciprocal for averaging: avg = (sum * RECIP) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    typedef struct packed {
        logic accum;
        logic avg_calc;
        logic mv_start;
        logic mv_save;
        logic pct_start;
        logic out_load;
    } bcg_cmd_t;

    typedef struct packed {
        logic div_busy;
    } bcg_status_t;

    function automatic logic [MV_W-1:0] bp_mv(input logic [BP_IDX_W-1:0] idx);
        logic [MV_W-1:0] v;
        case (idx)
            4'd0:    v = 13'd4200;
            4'd1:    v = 13'd4100;
            4'd2:    v = 13'd3970;
            4'd3:    v = 13'd3920;
            4'd4:    v = 13'd3870;
            4'd5:    v = 13'd3830;
            4'd6:    v = 13'd3790;
            4'd7:    v = 13'd3750;
            4'd8:    v = 13'd3700;
            4'd9:    v = 13'd3600;
            4'd10:   v = 13'd3300;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

    function automatic logic [PCT_W-1:0] bp_pct(input logic [BP_IDX_W-1:0] idx);
        logic [PCT_W-1:0] v;
        case (idx)
            4'd0:    v = 7'd100;
            4'd1:    v = 7'd90;
            4'd2:    v = 7'd80;
            4'd3:    v = 7'd70;
            4'd4:    v = 7'd60;
            4'd5:    v = 7'd50;
            4'd6:    v = 7'd40;
            4'd7:    v = 7'd30;
            4'd8:    v = 7'd20;
            4'd9:    v = 7'd10;
            4'd10:   v = 7'd5;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/bcg_sample_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_sample_if: raw converter sample channel
// Valid/ready channel carrying one 12-bit converter reading per word.
// ----------------------------------------------------------------------------
interface bcg_sample_if;
    logic                      valid;
    logic                      ready;
    logic [bcg_pkg::ADC_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

/* rtl/bcg_reading_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_reading_if: gauge reading channel
// Valid/ready channel carrying average count, millivolts and percent.
// ----------------------------------------------------------------------------
interface bcg_reading_if;
    logic                      valid;
    logic                      ready;
    logic [bcg_pkg::ADC_W-1:0] average_count;
    logic [bcg_pkg::MV_W-1:0]  millivolts;
    logic [bcg_pkg::PCT_W-1:0] percent;

    modport source (output valid, output average_count, output millivolts,
                    output percent, input ready);
    modport sink   (input valid, input average_count, input millivolts,
                    input percent, output ready);
endinterface

/* rtl/bcg_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_div: radix-2 restoring divider
// Produces one quotient bit per cycle for a programmable number of steps;
// the quotient collects in the low bits of the dividend shift register.
// ----------------------------------------------------------------------------
module bcg_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bcg_pkg::NUM_W-1:0]    num_in,
    input  logic [bcg_pkg::DEN_W-1:0]    den_in,
    input  logic [bcg_pkg::STEP_W-1:0]   steps_in,
    output logic                         busy,
    output logic [bcg_pkg::NUM_W-1:0]    quot
);
    import bcg_pkg::*;

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic [DEN_W:0]    partial;
    logic              qbit;

    always_comb
    begin
        partial  = {rem_reg, num_reg[NUM_W-1]};
        qbit     = (partial >= {1'b0, den_reg});
        rem_next = qbit ? DEN_W'(partial - {1'b0, den_reg}) : partial[DEN_W-1:0];
        num_next = {num_reg[NUM_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps_in;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= num_in;
            den_reg <= den_in;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign busy = busy_reg;
    assign quot = num_reg;

endmodule

/* rtl/bcg_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_datapath: accumulator, scaling and interpolation datapath
// Holds the sample sum, the reference register, the shared divider, the
// segment lookup and the output word register.
// ----------------------------------------------------------------------------
module bcg_datapath #(
    parameter int SAMPLES_PER_READING = bcg_pkg::SAMPLES_PER_READING_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bcg_pkg::bcg_cmd_t          cmd,
    output bcg_pkg::bcg_status_t       status,
    input  logic [bcg_pkg::ADC_W-1:0]  adc_sample,
    input  logic                       cfg_we,
    input  logic [bcg_pkg::ADC_W-1:0]  cfg_wdata,
    output logic [bcg_pkg::ADC_W-1:0]  average_count,
    output logic [bcg_pkg::MV_W-1:0]   millivolts,
    output logic [bcg_pkg::PCT_W-1:0]  percent
);
    import bcg_pkg::*;

    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

    logic [SUM_W-1:0]          sum_reg;
    logic [ADC_W-1:0]          full_count_reg;
    logic [ADC_W-1:0]          avg_reg;
    logic [MV_W-1:0]           mv_reg;
    logic [PCT_W-1:0]          base_reg;
    logic                      interp_reg;
    logic [ADC_W-1:0]          out_avg_reg;
    logic [MV_W-1:0]           out_mv_reg;
    logic [PCT_W-1:0]          out_pct_reg;

    logic [SUM_W+RECIP_W-1:0]  avg_prod;
    logic                      div_start;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic [STEP_W-1:0]         div_steps;
    logic                      div_busy;
    logic [NUM_W-1:0]          div_quot;

    logic [BP_IDX_W-1:0]       seg;
    logic [MV_W-1:0]           seg_lo;
    logic [MV_W-1:0]           seg_hi;
    logic [PCT_W-1:0]          seg_pct_lo;
    logic [PCT_W-1:0]          seg_dpct;
    logic [MV_W-1:0]           seg_off;
    logic [MV_W-1:0]           seg_prod;
    logic                      is_full;
    logic                      is_empty;

    assign avg_prod = (SUM_W+RECIP_W)'(sum_reg) * (SUM_W+RECIP_W)'(AVG_RECIP);

    always_comb
    begin
        seg = BP_IDX_W'(1);
        for (int k = 1; k < BP_COUNT; k++)
        begin
            if (mv_reg >= bp_mv(BP_IDX_W'(k)) && mv_reg < bp_mv(BP_IDX_W'(k - 1)))
            begin
                seg = BP_IDX_W'(k);
            end
        end
        seg_lo     = bp_mv(seg);
        seg_hi     = bp_mv(seg - 1'b1);
        seg_pct_lo = bp_pct(seg);
        seg_dpct   = bp_pct(seg - 1'b1) - seg_pct_lo;
        seg_off    = mv_reg - seg_lo;
        seg_prod   = MV_W'(seg_off[8:0]) * MV_W'(seg_dpct[3:0]);
        is_full    = (mv_reg >= MV_FULL);
        is_empty   = (mv_reg <= MV_EMPTY);
    end

    always_comb
    begin
        div_start = cmd.mv_start | cmd.pct_start;
        if (cmd.pct_start)
        begin
            div_num   = {PCT_NUM_W'(seg_prod), (NUM_W - PCT_NUM_W)'(0)};
            div_den   = DEN_W'(seg_hi - seg_lo);
            div_steps = STEP_W'(PCT_NUM_W);
        end
        else
        begin
            div_num   = NUM_W'(MV_FULL) * NUM_W'(avg_reg);
            div_den   = full_count_reg;
            div_steps = STEP_W'(NUM_W);
        end
    end

    bcg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num_in   (div_num),
        .den_in   (div_den),
        .steps_in (div_steps),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            full_count_reg <= FULL_COUNT_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                full_count_reg <= cfg_wdata;
            end
            if (cmd.accum)
            begin
                sum_reg <= SUM_W'(sum_reg + SUM_W'(adc_sample));
            end
            else if (cmd.avg_calc)
            begin
                sum_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.avg_calc)
        begin
            avg_reg <= avg_prod[RECIP_SHIFT +: ADC_W];
        end
        if (cmd.mv_save)
        begin
            mv_reg <= (div_quot > NUM_W'(MV_MAX)) ? MV_MAX : div_quot[MV_W-1:0];
        end
        if (cmd.pct_start)
        begin
            interp_reg <= !is_full && !is_empty;
            base_reg   <= is_full ? PCT_FULL : (is_empty ? PCT_EMPTY : seg_pct_lo);
        end
        if (cmd.out_load)
        begin
            out_avg_reg <= avg_reg;
            out_mv_reg  <= mv_reg;
            out_pct_reg <= interp_reg ? PCT_W'(base_reg + PCT_W'(div_quot[3:0])) : base_reg;
        end
    end

    assign status.div_busy = div_busy;
    assign average_count   = out_avg_reg;
    assign millivolts      = out_mv_reg;
    assign percent         = out_pct_reg;

endmodule

/* rtl/bcg_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_ctrl: gauge sequencer
// Counts accepted samples, steps the datapath through averaging, scaling
// and interpolation, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module bcg_ctrl #(
    parameter int SAMPLES_PER_READING = bcg_pkg::SAMPLES_PER_READING_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bcg_pkg::bcg_cmd_t     cmd,
    input  bcg_pkg::bcg_status_t  status
);
    import bcg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_MV_LOAD,
        ST_MV_RUN,
        ST_MV_SAVE,
        ST_PCT_RUN,
        ST_DONE
    } state_t;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_READING - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             in_fire;
    logic             out_free;

    assign in_fire  = (state_reg == ST_IDLE) && in_valid;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.accum = 1'b1;
                    if (count_reg == LAST_CNT)
                    begin
                        count_next = '0;
                        state_next = ST_AVG;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_AVG:
            begin
                cmd.avg_calc = 1'b1;
                state_next   = ST_MV_LOAD;
            end
            ST_MV_LOAD:
            begin
                cmd.mv_start = 1'b1;
                state_next   = ST_MV_RUN;
            end
            ST_MV_RUN:
            begin
                if (!status.div_busy)
                begin
                    cmd.mv_save = 1'b1;
                    state_next  = ST_MV_SAVE;
                end
            end
            ST_MV_SAVE:
            begin
                cmd.pct_start = 1'b1;
                state_next    = ST_PCT_RUN;
            end
            ST_PCT_RUN:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/battery_charge_gauge_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_gauge_core: single-cell state-of-charge gauge
// Averages converter samples and reports mean count, millivolts and percent.
// ----------------------------------------------------------------------------
// Usage:
//   sample  : sink channel, one 12-bit converter reading per word.
//   reading : source channel, one word per SAMPLES_PER_READING samples with
//             average count, cell millivolts and percent charge.
//   cfg_we / cfg_wdata : write of the full-cell reference, the mean count of
//             a 4.2 V cell.
// Sample flow: sample.ready is high whenever the sequencer is idle. After
//   the last sample of a reading, sample.ready stays low while the shared
//   one-bit-per-cycle divider forms the millivolt quotient and then the
//   interpolation quotient, and until the reading word is loaded.
//   The reading word becomes valid when it is loaded into the output register.
// Reset: clears the sum, the sample count and the output valid, and loads
//   the full-cell reference with 2280.
// Stall: the finished reading sits in the output register; samples keep
//   flowing, and the next finished reading waits, with sample.ready low,
//   until the previous one is taken.
// ----------------------------------------------------------------------------
module battery_charge_gauge_core #(
    parameter int SAMPLES_PER_READING = bcg_pkg::SAMPLES_PER_READING_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bcg_sample_if.sink                sample,
    bcg_reading_if.source             reading,
    input  logic                      cfg_we,
    input  logic [bcg_pkg::ADC_W-1:0] cfg_wdata
);
    import bcg_pkg::*;

    bcg_cmd_t    cmd;
    bcg_status_t status;

    bcg_ctrl #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (reading.valid),
        .out_ready (reading.ready),
        .cmd       (cmd),
        .status    (status)
    );

    bcg_datapath #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .adc_sample    (sample.adc_sample),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .average_count (reading.average_count),
        .millivolts    (reading.millivolts),
        .percent       (reading.percent)
    );

endmodule

/* rtl/bcg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_checker: port-level checks for the charge gauge
// Watches the top-level channels and the reading values over time.
// ----------------------------------------------------------------------------
module bcg_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [bcg_pkg::ADC_W-1:0] average_count,
    input logic [bcg_pkg::MV_W-1:0]  millivolts,
    input logic [bcg_pkg::PCT_W-1:0] percent
);
    import bcg_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average_count)
            && $stable(millivolts) && $stable(percent))
        else $error("reading word changed while stalled");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("sample ready dropped without an accepted word");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> percent <= PCT_FULL)
        else $error("percent above full scale");

    a_pct_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((percent == PCT_FULL) == (millivolts >= MV_FULL))
            && ((percent == PCT_EMPTY) == (millivolts <= MV_EMPTY)))
        else $error("percent end points disagree with millivolts");

endmodule

bind battery_charge_gauge_core bcg_checker u_bcg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .out_valid     (reading.valid),
    .out_ready     (reading.ready),
    .average_count (reading.average_count),
    .millivolts    (reading.millivolts),
    .percent       (reading.percent)
);

/* tb/battery_charge_gauge_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_gauge_core_test: self-checking bench for the charge gauge
// Streams converter samples in windows of ten and predicts each reading
// (mean count, saturated millivolts, interpolated percent) in a scoreboard.
// It steps through several reference settings, including zero, one and full
// scale. Random sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module battery_charge_gauge_core_test;
    import bcg_pkg::*;

    localparam int CLK_HALF          = 6;
    localparam int WINDOW            = SAMPLES_PER_READING_DEF;
    localparam int DRAIN_CYCLES      = 60;
    localparam int WINDOWS_PER_PHASE = 19;
    localparam int PHASES            = 6;
    localparam int RANDOM_REF_PHASE  = 4;

    localparam int unsigned KNEE_MV [BP_COUNT] = '{
        4200, 4100, 3970, 3920, 3870, 3830, 3790, 3750, 3700, 3600, 3300
    };
    localparam int unsigned KNEE_PCT [BP_COUNT] = '{
        100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 5
    };
    localparam logic [ADC_W-1:0] PHASE_REF [PHASES] = '{
        12'd2100, 12'd4095, 12'd1, 12'd0, 12'd2280, 12'd2280
    };

    typedef struct packed {
        logic [ADC_W-1:0] average_count;
        logic [MV_W-1:0]  millivolts;
        logic [PCT_W-1:0] percent;
    } gauge_reading_t;

    class charge_scoreboard;
        logic [ADC_W-1:0] full_count;
        int unsigned      window_sum;
        int unsigned      window_fill;
        gauge_reading_t   expected_readings[$];
        int               errors;

        function new();
            full_count  = FULL_COUNT_RST;
            window_sum  = 0;
            window_fill = 0;
            errors      = 0;
        endfunction

        function void set_reference(logic [ADC_W-1:0] value);
            full_count = value;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function int unsigned cell_millivolts(int unsigned avg);
            int unsigned quotient;
            if (full_count == '0)
                return MV_MAX;
            quotient = (MV_FULL * avg) / full_count;
            return (quotient > MV_MAX) ? MV_MAX : quotient;
        endfunction

        function int unsigned charge_percent(int unsigned mv);
            int unsigned lo;
            int unsigned hi;
            if (mv >= KNEE_MV[0])
                return PCT_FULL;
            if (mv <= KNEE_MV[BP_COUNT-1])
                return PCT_EMPTY;
            for (int k = 1; k < BP_COUNT; k++)
            begin
                lo = KNEE_MV[k];
                hi = KNEE_MV[k-1];
                if (mv >= lo && mv < hi)
                    return KNEE_PCT[k] + ((mv - lo) * (KNEE_PCT[k-1] - KNEE_PCT[k])) / (hi - lo);
            end
            return PCT_EMPTY;
        endfunction

        function void note_sample(logic [ADC_W-1:0] value);
            gauge_reading_t r;
            int unsigned    avg;
            int unsigned    mv;
            window_sum  = (window_sum + value) & 32'h0000_FFFF;
            window_fill = window_fill + 1;
            if (window_fill == WINDOW)
            begin
                avg = (window_sum / WINDOW) & 32'h0000_0FFF;
                mv  = cell_millivolts(avg);
                r.average_count = ADC_W'(avg);
                r.millivolts    = MV_W'(mv);
                r.percent       = PCT_W'(charge_percent(mv));
                expected_readings.push_back(r);
                window_sum  = 0;
                window_fill = 0;
            end
        endfunction

        function void check_reading(gauge_reading_t got);
            gauge_reading_t want;
            if (expected_readings.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reading avg=%0d mv=%0d pct=%0d", $time,
                         got.average_count, got.millivolts, got.percent);
                return;
            end
            want = expected_readings.pop_front();
            if (got.average_count !== want.average_count)
            begin
                errors++;
                $display("%0t: average_count expected %0d got %0d", $time,
                         want.average_count, got.average_count);
            end
            if (got.millivolts !== want.millivolts)
            begin
                errors++;
                $display("%0t: millivolts expected %0d got %0d", $time,
                         want.millivolts, got.millivolts);
            end
            if (got.percent !== want.percent)
            begin
                errors++;
                $display("%0t: percent expected %0d got %0d", $time,
                         want.percent, got.percent);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [ADC_W-1:0] cfg_wdata;
    int               src_idle_pct;
    int               snk_stall_pct;
    logic [ADC_W-1:0] phase_ref;

    charge_scoreboard sb = new();

    bcg_sample_if  smp();
    bcg_reading_if rdg();

    battery_charge_gauge_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp),
        .reading   (rdg),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: stall at random on the falling edge
    initial
    begin
        rdg.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rdg.ready <= rst_n && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial
    begin
        gauge_reading_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rdg.valid === 1'b1 && rdg.ready === 1'b1)
            begin
                got.average_count = rdg.average_count;
                got.millivolts    = rdg.millivolts;
                got.percent       = rdg.percent;
                sb.check_reading(got);
            end
        end
    end

    task automatic send_sample(input logic [ADC_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            smp.valid <= 1'b0;
            @(negedge clk);
        end
        smp.valid      <= 1'b1;
        smp.adc_sample <= value;
        @(posedge clk);
        while (smp.ready !== 1'b1)
            @(posedge clk);
        sb.note_sample(value);
    endtask

    task automatic end_burst();
        @(negedge clk);
        smp.valid <= 1'b0;
    endtask

    task automatic write_reference(input logic [ADC_W-1:0] value);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reference(value);
    endtask

    // aim the window mean at a voltage near a knee or in the useful band, or send random words
    task automatic send_random_window(input logic [ADC_W-1:0] full);
        int unsigned      mode;
        int unsigned      mv_target;
        int unsigned      avg;
        int unsigned      spread;
        logic [ADC_W-1:0] word_buf [WINDOW];
        mode = $urandom_range(9);
        if (mode >= 7)
        begin
            foreach (word_buf[i])
                word_buf[i] = ADC_W'($urandom_range(4095));
        end
        else
        begin
            if (mode < 4)
                mv_target = KNEE_MV[$urandom_range(BP_COUNT-1)] + $urandom_range(4) - 2;
            else
                mv_target = $urandom_range(4400, 2900);
            if (full == '0)
                avg = $urandom_range(4095);
            else
                avg = (mv_target * full + MV_FULL - 1) / MV_FULL;
            if (avg > 4095)
                avg = 4095;
            spread = $urandom_range((avg < 4095 - avg) ? avg : 4095 - avg);
            foreach (word_buf[i])
                word_buf[i] = ADC_W'((i % 2 == 0) ? avg + spread : avg - spread);
        end
        foreach (word_buf[i])
            send_sample(word_buf[i]);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        smp.valid      = 1'b0;
        smp.adc_sample = '0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full-scale and zero words, exact full boundary, empty cell
        for (int i = 0; i < WINDOW; i++)
            send_sample((i % 2 == 0) ? '1 : '0);
        repeat (WINDOW) send_sample(FULL_COUNT_RST);
        repeat (WINDOW) send_sample('0);
        end_burst();

        for (int p = 0; p < PHASES; p++)
        begin
            phase_ref = (p == RANDOM_REF_PHASE) ? ADC_W'($urandom_range(3500, 1500))
                                                : PHASE_REF[p];
            write_reference(phase_ref);
            case (p % 4)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 45; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 45; end
                default: begin src_idle_pct = 33; snk_stall_pct = 33; end
            endcase
            repeat (WINDOWS_PER_PHASE) send_random_window(phase_ref);
            end_burst();
        end

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
